// ----- hw/rtl/liwp_pkg.sv -----
// Shared constants, entry layout and control structs for the increasing weight path block.
`default_nettype none

package liwp_pkg;

    localparam int VERTICES    = 65536;
    localparam int ADDR_BITS   = $clog2(VERTICES);
    localparam int VTX_BITS    = 16;
    localparam int WEIGHT_BITS = 17;
    localparam int LENGTH_BITS = 20;
    localparam int TAG_BITS    = WEIGHT_BITS + 1;
    localparam int COUNT_BITS  = 17;

    localparam logic [LENGTH_BITS-1:0] L_MAX        = '1;
    localparam logic [TAG_BITS-1:0]    TAG_NONE     = '1;
    localparam logic [COUNT_BITS-1:0]  VERTICES_CNT = COUNT_BITS'(VERTICES);

    typedef struct packed {
        logic [LENGTH_BITS-1:0] best;
        logic [LENGTH_BITS-1:0] prior;
        logic [TAG_BITS-1:0]    tag;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{best: '0, prior: '0, tag: TAG_NONE};

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        t_entry               data;
    } t_ram_wr;

    typedef struct packed {
        logic                 busy;
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
    } t_clr_stat;

    typedef struct packed {
        logic                   valid;
        logic                   apply;
        logic                   last;
        logic                   err;
        logic [ADDR_BITS-1:0]   src;
        logic [ADDR_BITS-1:0]   dst;
        logic [WEIGHT_BITS-1:0] wt;
        logic [COUNT_BITS-1:0]  lim;
    } t_stage;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] longest;
        logic                   err;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/liwp_edge_if.sv -----
// Edge input channel: valid, ready and one edge as payload.
`default_nettype none

interface liwp_edge_if;
    logic                               valid;
    logic                               ready;
    logic [liwp_pkg::VTX_BITS-1:0]      src_vertex;
    logic [liwp_pkg::VTX_BITS-1:0]      dst_vertex;
    logic [liwp_pkg::WEIGHT_BITS-1:0]   edge_weight;
    logic                               last_edge;

    modport source (output valid, src_vertex, dst_vertex, edge_weight, last_edge,
                    input ready);
    modport sink (input valid, src_vertex, dst_vertex, edge_weight, last_edge,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/liwp_res_if.sv -----
// Result output channel: valid, ready and one path result as payload.
`default_nettype none

interface liwp_res_if;
    logic                               valid;
    logic                               ready;
    logic [liwp_pkg::LENGTH_BITS-1:0]   longest_path;
    logic                               order_error;

    modport source (output valid, longest_path, order_error, input ready);
    modport sink (input valid, longest_path, order_error, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/liwp_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module liwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/liwp_clear.sv -----
// Clearing sequencer that returns the active vertex entries to their reset value.
`default_nettype none

module liwp_clear (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [liwp_pkg::COUNT_BITS-1:0]     i_lim,
    output liwp_pkg::t_clr_stat                      o_stat
);

    logic                            r_busy;
    logic [liwp_pkg::COUNT_BITS-1:0] r_idx;
    logic [liwp_pkg::COUNT_BITS-1:0] r_lim;
    logic [liwp_pkg::COUNT_BITS-1:0] idx_next;

    assign idx_next = liwp_pkg::COUNT_BITS'(r_idx + 1'b1);

    // After reset the whole store is swept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_lim  <= liwp_pkg::VERTICES_CNT;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_lim  <= i_lim;
        end else if (r_busy) begin
            if (idx_next >= r_lim) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= idx_next;
            end
        end
    end

    // An empty range still passes through the busy state, but writes nothing.
    always_comb begin
        o_stat.busy = r_busy;
        o_stat.we   = r_busy && (r_idx < r_lim);
        o_stat.addr = r_idx[liwp_pkg::ADDR_BITS-1:0];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/liwp_update.sv -----
// Read-modify-write stage: forwarding, candidate length and destination entry update.
`default_nettype none

module liwp_update (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  liwp_pkg::t_stage                          i_stage,
    input  liwp_pkg::t_entry                          i_rd_src,
    input  liwp_pkg::t_entry                          i_rd_dst,
    input  liwp_pkg::t_ram_wr                         i_ram_wr,
    output liwp_pkg::t_ram_wr                         o_wr,
    output logic [liwp_pkg::LENGTH_BITS-1:0]          o_cand
);

    logic                           r_fw_valid;
    logic [liwp_pkg::ADDR_BITS-1:0] r_fw_addr;
    liwp_pkg::t_entry               r_fw_data;

    liwp_pkg::t_entry                 src_e;
    liwp_pkg::t_entry                 dst_e;
    liwp_pkg::t_entry                 new_e;
    logic [liwp_pkg::TAG_BITS-1:0]    wtag;
    logic [liwp_pkg::LENGTH_BITS-1:0] src_len;
    logic [liwp_pkg::LENGTH_BITS-1:0] cand;

    // The RAM write that lands on the same edge as the reads is not seen by
    // them, so it is registered and forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= i_ram_wr.we;
        end
        r_fw_addr <= i_ram_wr.addr;
        r_fw_data <= i_ram_wr.data;
    end

    always_comb begin
        src_e = (r_fw_valid && (r_fw_addr == i_stage.src)) ? r_fw_data : i_rd_src;
        dst_e = (r_fw_valid && (r_fw_addr == i_stage.dst)) ? r_fw_data : i_rd_dst;
        wtag  = {1'b0, i_stage.wt};

        // Within its own weight group a source shows its length from before
        // the group, so edges of equal weight never chain.
        src_len = (src_e.tag == wtag) ? src_e.prior : src_e.best;
        cand    = (src_len == liwp_pkg::L_MAX) ? liwp_pkg::L_MAX
                                               : liwp_pkg::LENGTH_BITS'(src_len + 1'b1);

        new_e = dst_e;
        if (dst_e.tag != wtag) begin
            new_e.prior = dst_e.best;
            new_e.tag   = wtag;
        end
        if (cand > dst_e.best) begin
            new_e.best = cand;
        end

        o_wr.we   = i_stage.valid && i_stage.apply;
        o_wr.addr = i_stage.dst;
        o_wr.data = new_e;
        o_cand    = cand;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/longest_increasing_weight_path_core.sv -----
// Top level of the longest strictly increasing edge weight path block.
//
// Edges arrive on i_edge in nondecreasing weight order, one transaction per edge.
// The edge marked last_edge closes the graph and produces one transaction on o_res
// with the longest path length (saturating) and a sticky order error flag.
// Edges that fall outside vertex_count are dropped; a decreasing weight is dropped
// and flags the error. vertex_count is written through i_cfg_we / i_cfg_data.
//
// Throughput is one edge per cycle while i_edge.ready is high: each edge reads its
// source and destination entry from a dual-read vertex RAM and writes the destination
// back in the next cycle, with the write of the previous edge forwarded. The result
// passes through the update stage and then the output register (or, while o_res
// stalls, the skid register). After a last edge, i_edge.ready stays low while it is in
// the update stage and while the store is cleared one entry per cycle, up to
// L = min(vertex_count, 65536) entries. After reset the clearing pass covers all
// 65536 entries before the block takes its first edge. vertex_count resets to 65536.
// When o_res stalls, edges are still accepted; a second result waits in a skid
// register and holds off new edges until the output register frees up.
`default_nettype none

module longest_increasing_weight_path_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [liwp_pkg::COUNT_BITS-1:0]    i_cfg_data,
    liwp_edge_if.sink                               i_edge,
    liwp_res_if.source                              o_res
);

    // Configuration and per-graph scalar state.
    logic [liwp_pkg::COUNT_BITS-1:0]  r_vertex_count;
    logic [liwp_pkg::WEIGHT_BITS-1:0] r_cur_weight;
    logic                             r_err;
    logic [liwp_pkg::LENGTH_BITS-1:0] r_run_max;
    logic [liwp_pkg::LENGTH_BITS-1:0] n_run_max;

    // Edge in the read-modify-write stage.
    liwp_pkg::t_stage r_s1;
    liwp_pkg::t_stage n_s1;

    // Output register and skid register.
    logic              r_out_valid;
    liwp_pkg::t_result r_out;
    logic              r_pend_valid;
    liwp_pkg::t_result r_pend;
    liwp_pkg::t_result s1_result;

    logic                            accept;
    logic                            draining;
    logic                            s1_done_last;
    logic                            err_now;
    logic                            in_range;
    logic [liwp_pkg::COUNT_BITS-1:0] lim;

    liwp_pkg::t_clr_stat              clr;
    liwp_pkg::t_ram_wr                upd_wr;
    liwp_pkg::t_ram_wr                ram_wr;
    liwp_pkg::t_entry                 rd_src;
    liwp_pkg::t_entry                 rd_dst;
    logic [liwp_pkg::LENGTH_BITS-1:0] cand;
    logic [$bits(liwp_pkg::t_entry)-1:0] rdata_a;
    logic [$bits(liwp_pkg::t_entry)-1:0] rdata_b;

    // New edges wait while the store is cleared, while a last edge is still in
    // the update stage, and while a result sits in the skid register.
    assign i_edge.ready = !clr.busy && !r_pend_valid && !(r_s1.valid && r_s1.last);
    assign accept       = i_edge.valid && i_edge.ready;
    assign draining     = r_out_valid && o_res.ready;
    assign s1_done_last = r_s1.valid && r_s1.last;

    assign lim = (r_vertex_count < liwp_pkg::VERTICES_CNT) ? r_vertex_count
                                                           : liwp_pkg::VERTICES_CNT;

    always_comb begin
        err_now  = i_edge.edge_weight < r_cur_weight;
        in_range = ({1'b0, i_edge.src_vertex} < lim) && ({1'b0, i_edge.dst_vertex} < lim);

        n_s1.valid = accept;
        n_s1.apply = !err_now && in_range;
        n_s1.last  = i_edge.last_edge;
        n_s1.err   = r_err || err_now;
        n_s1.src   = i_edge.src_vertex[liwp_pkg::ADDR_BITS-1:0];
        n_s1.dst   = i_edge.dst_vertex[liwp_pkg::ADDR_BITS-1:0];
        n_s1.wt    = i_edge.edge_weight;
        n_s1.lim   = lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= liwp_pkg::VERTICES_CNT;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // The weight order check and the error flag live at the accept point; the
    // flag travels with the last edge so the result sees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_weight <= '0;
            r_err        <= 1'b0;
            r_s1.valid   <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
            if (accept) begin
                if (i_edge.last_edge) begin
                    r_cur_weight <= '0;
                    r_err        <= 1'b0;
                end else begin
                    r_err <= n_s1.err;
                    if (n_s1.apply) begin
                        r_cur_weight <= i_edge.edge_weight;
                    end
                end
            end
        end
        r_s1.apply <= n_s1.apply;
        r_s1.last  <= n_s1.last;
        r_s1.err   <= n_s1.err;
        r_s1.src   <= n_s1.src;
        r_s1.dst   <= n_s1.dst;
        r_s1.wt    <= n_s1.wt;
        r_s1.lim   <= n_s1.lim;
    end

    liwp_ram #(
        .WIDTH ($bits(liwp_pkg::t_entry)),
        .DEPTH (liwp_pkg::VERTICES)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_wr.we),
        .i_waddr   (ram_wr.addr),
        .i_wdata   (ram_wr.data),
        .i_raddr_a (n_s1.src),
        .i_raddr_b (n_s1.dst),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign rd_src = liwp_pkg::t_entry'(rdata_a);
    assign rd_dst = liwp_pkg::t_entry'(rdata_b);

    liwp_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (r_s1),
        .i_rd_src (rd_src),
        .i_rd_dst (rd_dst),
        .i_ram_wr (ram_wr),
        .o_wr     (upd_wr),
        .o_cand   (cand)
    );

    liwp_clear u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s1_done_last),
        .i_lim   (r_s1.lim),
        .o_stat  (clr)
    );

    // Clearing starts only after the last edge has written back, so the two
    // write sources never meet.
    always_comb begin
        if (upd_wr.we) begin
            ram_wr = upd_wr;
        end else begin
            ram_wr.we   = clr.we;
            ram_wr.addr = clr.addr;
            ram_wr.data = liwp_pkg::ENTRY_RESET;
        end
    end

    always_comb begin
        n_run_max = r_run_max;
        if (upd_wr.we && (cand > r_run_max)) begin
            n_run_max = cand;
        end
        s1_result.longest = n_run_max;
        s1_result.err     = r_s1.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_max <= '0;
        end else if (r_s1.valid) begin
            r_run_max <= r_s1.last ? '0 : n_run_max;
        end
    end

    // The result goes straight to the output register when it is free,
    // otherwise into the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (s1_done_last) begin
            if (!r_out_valid || draining) begin
                r_out_valid <= 1'b1;
                r_out       <= s1_result;
            end else begin
                r_pend_valid <= 1'b1;
                r_pend       <= s1_result;
            end
        end else if (r_pend_valid && (!r_out_valid || draining)) begin
            r_out_valid  <= 1'b1;
            r_out        <= r_pend;
            r_pend_valid <= 1'b0;
        end else if (draining) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.longest_path = r_out.longest;
    assign o_res.order_error  = r_out.err;

`ifndef ASSERT_OFF
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(upd_wr.we && clr.we))
        else $error("update write and clearing write in the same cycle");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_hold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_edge.last_edge) |=> !i_edge.ready)
        else $error("edge taken directly behind a last edge");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_done_last |=> clr.busy)
        else $error("no clearing pass after a last edge");
`endif

endmodule

`default_nettype wire
